>>> hdl/ais_pkg.sv
package ais_pkg;

	localparam int unsigned SetDepthDefault = 64;
	localparam int unsigned ValueWidth      = 32;

	typedef logic signed [ValueWidth-1:0] value_t;

	typedef enum logic [0:0] {
		ST_FILL,
		ST_DRAIN
	} ais_state_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic   ins;
		logic   shl;
		value_t new_value;
	} ais_ctl_t;

endpackage

>>> hdl/ascending_integer_sorter_top.sv
// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_ready  value, last
// result    out        res_valid / res_ready  value_res, last_res
//
// On each accepted request all cells compare the new value at once and the cells
// above the insertion point shift up by one. The flagged request starts the drain,
// where the chain shifts down one cell per accepted result, so a set of N values
// returns its N results when N is at most SET_DEPTH.
// Requests are not taken while a set drains. Reset empties the chain at once.
// A stalled result holds in the lowest cell until it is taken.
module ascending_integer_sorter_top
	import ais_pkg::*;
#(
	parameter int unsigned SET_DEPTH = SetDepthDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic signed [ValueWidth-1:0] value,
	input  logic                        last,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic signed [ValueWidth-1:0] value_res,
	output logic                        last_res
);

	ais_state_t state_q;
	ais_state_t state_d;
	ais_ctl_t   ctl;

	value_t cell_value [SET_DEPTH];
	logic   cell_valid [SET_DEPTH];
	logic   cell_keep  [SET_DEPTH];

	logic req_take;
	logic res_take;
	logic full;

	// The top cell holds a value only when the chain is full.
	assign full     = cell_valid[SET_DEPTH-1];
	assign req_take = req_valid && req_ready;
	assign res_take = res_valid && res_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (req_take && last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (res_take && !cell_valid[1]) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		res_valid     = 1'b0;
		ctl.ins       = 1'b0;
		ctl.shl       = 1'b0;
		ctl.new_value = value;
		unique case (state_q)
			ST_FILL: begin
				req_ready = 1'b1;
				ctl.ins   = req_valid && !full;
			end
			ST_DRAIN: begin
				res_valid = cell_valid[0];
				ctl.shl   = cell_valid[0] && res_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign value_res = cell_value[0];
	assign last_res  = !cell_valid[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
		logic   prev_keep;
		value_t prev_value;
		logic   prev_valid;
		value_t next_value;
		logic   next_valid;

		if (i == 0) begin : g_first
			assign prev_keep  = 1'b1;
			assign prev_value = '0;
			assign prev_valid = 1'b0;
		end else begin : g_inner
			assign prev_keep  = cell_keep[i-1];
			assign prev_value = cell_value[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == SET_DEPTH - 1) begin : g_last
			assign next_value = '0;
			assign next_valid = 1'b0;
		end else begin : g_body
			assign next_value = cell_value[i+1];
			assign next_valid = cell_valid[i+1];
		end

		ais_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_keep (prev_keep),
			.prev_value(prev_value),
			.prev_valid(prev_valid),
			.next_value(next_value),
			.next_valid(next_valid),
			.value     (cell_value[i]),
			.valid     (cell_valid[i]),
			.keep      (cell_keep[i])
		);
	end

endmodule

>>> hdl/ais_cell.sv
module ais_cell
	import ais_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ais_ctl_t ctl,
	input  logic     prev_keep,
	input  value_t   prev_value,
	input  logic     prev_valid,
	input  value_t   next_value,
	input  logic     next_valid,
	output value_t   value,
	output logic     valid,
	output logic     keep
);

	value_t value_q;
	logic   valid_q;

	// The chain is sorted ascending, so the cells that keep their value form a prefix.
	assign keep  = valid_q && (value_q <= ctl.new_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end else if (ctl.shl) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			value_q <= prev_keep ? ctl.new_value : prev_value;
		end else if (ctl.shl) begin
			value_q <= next_value;
		end
	end

endmodule

>>> hdl/ais_checker.sv
module ais_checker
	import ais_pkg::*;
(
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic signed [ValueWidth-1:0] value,
	input logic                         last,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic signed [ValueWidth-1:0] value_res,
	input logic                         last_res
);

	// A request that waits keeps its payload.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(value) && $stable(last))
		else $error("request changed while stalled");

	// A result that waits keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value_res) && $stable(last_res))
		else $error("result changed while stalled");

	// No request is taken while a set drains.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("request ready during drain");

	// The flagged request starts the drain in the next cycle.
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && last |=> res_valid)
		else $error("no result after final request");

	// After the final result the block is empty and takes requests again.
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && last_res |=> !res_valid && req_ready)
		else $error("block not empty after final result");

endmodule

bind ascending_integer_sorter_top ais_checker u_ais_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.value    (value),
	.last     (last),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.value_res(value_res),
	.last_res (last_res)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ais_pkg::*;

	localparam int unsigned SET_DEPTH    = SetDepthDefault;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned ITEM_TARGET  = 230;
	localparam int unsigned DIRECTED_LEN = 24;

	typedef struct packed {
		value_t value;
		logic   last;
	} sorted_word_t;

	// One row of the directed table. Rows marked typed carry their own expected
	// result; those are single-value sets, so the result is the value itself.
	typedef struct packed {
		value_t value;
		logic   last;
		logic   typed;
		value_t exp_value;
	} stim_row_t;

	localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
		'{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
		'{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF},
		'{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
		'{32'shFFFFFFFF, 1'b1, 1'b1, 32'shFFFFFFFF},
		'{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0},
		'{32'sh80000000, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000000, 1'b1, 1'b0, 32'sh0},
		'{32'sh00000005, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000005, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFFFFFB, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000005, 1'b1, 1'b0, 32'sh0},
		'{32'sh00000001, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFFFFFF, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000002, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFFFFFE, 1'b1, 1'b0, 32'sh0},
		'{32'sh00000003, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000002, 1'b0, 1'b0, 32'sh0},
		'{32'sh00000001, 1'b1, 1'b0, 32'sh0},
		'{32'sh55555555, 1'b0, 1'b0, 32'sh0},
		'{32'shAAAAAAAA, 1'b0, 1'b0, 32'sh0},
		'{32'sh55555555, 1'b1, 1'b0, 32'sh0},
		'{32'sh80000001, 1'b0, 1'b0, 32'sh0},
		'{32'sh7FFFFFFE, 1'b0, 1'b0, 32'sh0},
		'{32'sh80000000, 1'b1, 1'b0, 32'sh0}
	};

	logic   clk;
	logic   arst_n    = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_ready;
	value_t value     = '0;
	logic   last      = 1'b0;
	logic   res_valid;
	logic   res_ready = 1'b0;
	value_t value_res;
	logic   last_res;

	// Predictor state: the values of the set being collected, kept in order.
	value_t       held_values[$];
	logic [6:0]   held_count = '0;
	logic         held_dropped = 1'b0;
	sorted_word_t sorted_expect[$];

	int unsigned request_count   = 0;
	int unsigned set_count       = 0;
	int unsigned overflow_sets   = 0;
	int unsigned results_checked = 0;
	int unsigned error_count     = 0;
	int unsigned idle_cycles     = 0;
	int unsigned burst_left      = 0;
	logic        held_off        = 1'b0;

	ascending_integer_sorter_top #(
		.SET_DEPTH(SET_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.value    (value),
		.last     (last),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.value_res(value_res),
		.last_res (last_res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Inserts an accepted request into the ordered set unless the set is full; a
	// flagged request releases the whole set as expected results.
	task automatic absorb_request(input value_t v, input logic l);
		int unsigned  pos;
		int unsigned  k;
		sorted_word_t word;
		if (held_count < SET_DEPTH) begin
			pos = 0;
			while (pos < held_values.size() && held_values[pos] <= v)
				pos++;
			held_values.insert(pos, v);
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (l) begin
			for (k = 0; k < held_values.size(); k++) begin
				word.value = held_values[k];
				word.last  = (k + 1 == held_values.size());
				sorted_expect.push_back(word);
			end
			set_count++;
			if (held_dropped)
				overflow_sets++;
			held_values.delete();
			held_count   = '0;
			held_dropped = 1'b0;
		end
	endtask

	// Offers one request, waits for it to be taken, then updates the predictor.
	task automatic send_request(input value_t v, input logic l, input logic typed,
			input value_t exp_v);
		int unsigned  before_len;
		sorted_word_t word;
		req_valid <= 1'b1;
		value     <= v;
		last      <= l;
		do
			@(posedge clk);
		while (!req_ready);
		request_count++;
		before_len = sorted_expect.size();
		absorb_request(v, l);
		if (typed) begin
			while (sorted_expect.size() > before_len)
				void'(sorted_expect.pop_back());
			word.value = exp_v;
			word.last  = 1'b1;
			sorted_expect.push_back(word);
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	function automatic value_t random_value();
		value_t v;
		case ($urandom_range(0, 3))
			0: v = value_t'($urandom);
			1: v = value_t'(int'($urandom_range(0, 16)) - 8);
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh80000000;
					1: v = 32'sh7FFFFFFF;
					2: v = 32'sh00000000;
					default: v = 32'shFFFFFFFF;
				endcase
			end
			default: begin
				if ($urandom_range(0, 1) == 0)
					v = value_t'(32'h80000000 + $urandom_range(0, 4));
				else
					v = value_t'(32'h7FFFFFFF - $urandom_range(0, 4));
			end
		endcase
		return v;
	endfunction

	initial begin : request_source
		int unsigned row;
		int unsigned set_idx;
		int unsigned set_len;
		int unsigned k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_LEN; row++)
			send_request(DIRECTED[row].value, DIRECTED[row].last, DIRECTED[row].typed,
				DIRECTED[row].exp_value);

		// Mostly short sets; one exactly fills the store and one overflows it,
		// dropping the flagged request too.
		set_idx = 0;
		while (request_count < ITEM_TARGET) begin
			if (set_idx == 2)
				set_len = SET_DEPTH;
			else if (set_idx == 6)
				set_len = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 6);
			else
				set_len = $urandom_range(1, 12);
			for (k = 0; k < set_len; k++)
				send_request(random_value(), k + 1 == set_len, 1'b0, '0);
			set_idx++;
		end
		req_valid <= 1'b0;

		while (sorted_expect.size() != 0)
			@(posedge clk);
		repeat (SET_DEPTH + 8) @(posedge clk);

		$display("Sent %0d requests in %0d sets (%0d overflowed the store); checked %0d results.",
			request_count, set_count, overflow_sets, results_checked);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_sink
		int unsigned mode;
		int unsigned span;
		int unsigned step;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 60);
			for (step = 0; step < span; step++) begin
				@(posedge clk);
				// Hold off once while a full set drains, so that the sender
				// backs up behind it.
				if (!held_off && res_valid && sorted_expect.size() >= 32) begin
					res_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					held_off = 1'b1;
				end else begin
					case (mode)
						0: res_ready <= 1'b1;
						1: res_ready <= $urandom_range(0, 1);
						2: res_ready <= ($urandom_range(0, 3) != 0);
						default: res_ready <= (step % 3 == 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		sorted_word_t want;
		if (arst_n && res_valid && res_ready) begin
			if (sorted_expect.size() == 0) begin
				$error("unexpected result: value_res %0d, last_res %0b", value_res, last_res);
				error_count++;
			end else begin
				want = sorted_expect.pop_front();
				results_checked++;
				if (value_res !== want.value) begin
					$error("value_res: expected %0d, actual %0d", want.value, value_res);
					error_count++;
				end
				if (last_res !== want.last) begin
					$error("last_res: expected %0b, actual %0b", want.last, last_res);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no request or result moved for %0d cycles.", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
